@@ rtl/core/bpa_pkg.sv @@
package bpa_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned ORDER_W     = 3;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // Request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ORDER = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 2'd3;

  // Bitmap RAM access strobes
  typedef struct packed {
    logic rd;
    logic wr;
  } map_cmd_t;

  // Finished result offered by the sequencer
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   block;
  } bpa_res_t;

endpackage

@@ rtl/core/bpa_map_ram.sv @@
// Free bitmap store: one row per TOP_PAGES blocks, all orders in one RAM.
// Row valid bits stand in for the reset contents.
module bpa_map_ram #(
  parameter int unsigned ROWS = 15,
  parameter int unsigned RAW  = 4,
  parameter int unsigned W    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpa_pkg::map_cmd_t  cmd_i,
  input  logic [RAW-1:0]     addr_i,
  input  logic [W-1:0]       wdata_i,
  output logic [W-1:0]       rdata_o
);

  // Top-order row: all blocks free except the last one
  localparam logic [W-1:0] TOP_RESET = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0] mem_q [ROWS];
  logic [ROWS-1:0] vld_q;
  logic [W-1:0] rd_data_q;
  logic         rd_vld_q;
  logic         rd_top_q;

  // Row storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  // Written-since-reset marks and read tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_top_q <= 1'b0;
    end else begin
      if (cmd_i.wr) begin
        vld_q[addr_i] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rd_vld_q <= vld_q[addr_i];
        rd_top_q <= (addr_i == '0);
      end
    end
  end

  // Unwritten rows read as their reset contents
  always_comb begin
    if (rd_vld_q) begin
      rdata_o = rd_data_q;
    end else if (rd_top_q) begin
      rdata_o = TOP_RESET;
    end else begin
      rdata_o = '0;
    end
  end

endmodule

@@ rtl/core/bpa_seq.sv @@
// Request sequencer: walks the orders with one row read-modify-write unit.
module bpa_seq #(
  parameter int unsigned LOG_MIN   = 8,
  parameter int unsigned TOP_ORDER = 3,
  parameter int unsigned LOG_TP    = 4,
  parameter int unsigned RAW       = 4,
  parameter int unsigned W         = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          mode_i,
  input  logic [bpa_pkg::ORDER_W-1:0]   order_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    address_i,
  input  logic [bpa_pkg::ADDR_W-1:0]    region_base_i,
  input  logic                          out_free_i,
  output logic                          idle_o,
  output bpa_pkg::bpa_res_t             res_o,
  output bpa_pkg::map_cmd_t             map_cmd_o,
  output logic [RAW-1:0]                map_addr_o,
  output logic [W-1:0]                  map_wdata_o,
  input  logic [W-1:0]                  map_rdata_i
);

  localparam int unsigned IDXW       = LOG_TP + TOP_ORDER;
  localparam int unsigned RW         = TOP_ORDER;
  localparam int unsigned LOG_REGION = IDXW + LOG_MIN;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FREE_RD   = 4'd1;
  localparam logic [3:0] S_FREE_CHK  = 4'd2;
  localparam logic [3:0] S_ALLOC_RD  = 4'd3;
  localparam logic [3:0] S_ALLOC_CHK = 4'd4;
  localparam logic [3:0] S_SPLIT_RD  = 4'd5;
  localparam logic [3:0] S_SPLIT_WR  = 4'd6;
  localparam logic [3:0] S_ADDR      = 4'd7;
  localparam logic [3:0] S_SUM       = 4'd8;
  localparam logic [3:0] S_DONE      = 4'd9;

  logic [3:0]                        state_q, state_d;
  logic [bpa_pkg::ORDER_W-1:0]       ord_q, ord_d;
  logic [bpa_pkg::ORDER_W-1:0]       o_q, o_d;
  logic [IDXW-1:0]                   idx_q, idx_d;
  logic [RW-1:0]                     r_q, r_d;
  logic [bpa_pkg::STATUS_W-1:0]      status_q, status_d;
  logic [bpa_pkg::ADDR_W-1:0]        blk_q, blk_d;
  logic [bpa_pkg::ADDR_W-1:0]        shift_q, shift_d;

  // First row of an order: top order at row 0, each lower order below it
  function automatic logic [RAW-1:0] order_base(input logic [bpa_pkg::ORDER_W-1:0] o);
    logic [31:0] b;
    b = (32'd1 << (TOP_ORDER - 32'(o))) - 32'd1;
    return b[RAW-1:0];
  endfunction

  // RAM row holding block idx of order o
  function automatic logic [RAW-1:0] row_of(input logic [bpa_pkg::ORDER_W-1:0] o,
                                            input logic [IDXW-1:0] idx);
    logic [IDXW-1:0] r;
    r = idx >> LOG_TP;
    return order_base(o) + RAW'(r);
  endfunction

  // Lowest set bit of a row
  function automatic logic [LOG_TP-1:0] first_set(input logic [W-1:0] row);
    logic [LOG_TP-1:0] c;
    c = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (row[i]) begin
        c = LOG_TP'(i);
      end
    end
    return c;
  endfunction

  logic [32:0]             diff;
  logic [32:0]             diff_hi;
  logic [31:0]             off_sh;
  logic                    outside;
  logic [LOG_TP-1:0]       col;
  logic [LOG_TP-1:0]       bcol;
  logic [LOG_TP-1:0]       fcol;
  logic [IDXW-1:0]         fidx;
  logic [RW-1:0]           last_row;
  logic [63:0]             sh;

  // Request checks and offset to block index
  assign diff    = {1'b0, address_i} - {1'b0, region_base_i};
  assign diff_hi = {1'b0, diff[31:0]} >> LOG_REGION;
  assign outside = diff[32] | (diff_hi != '0);
  assign off_sh  = diff[31:0] >> (LOG_MIN + 32'(order_i));

  // Row unit operands
  assign col      = idx_q[LOG_TP-1:0];
  assign bcol     = col ^ LOG_TP'(1);
  assign fcol     = first_set(map_rdata_i);
  assign fidx     = IDXW'({r_q, fcol});
  assign last_row = RW'((32'd1 << (TOP_ORDER - 32'(o_q))) - 32'd1);
  assign sh       = {{(64 - IDXW){1'b0}}, idx_q} << (LOG_MIN + 32'(ord_q));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    ord_d       = ord_q;
    o_d         = o_q;
    idx_d       = idx_q;
    r_d         = r_q;
    status_d    = status_q;
    blk_d       = blk_q;
    shift_d     = shift_q;
    map_cmd_o   = '0;
    map_addr_o  = row_of(o_q, idx_q);
    map_wdata_o = map_rdata_i;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          status_d = bpa_pkg::ST_OK;
          blk_d    = '0;
          o_d      = order_i;
          ord_d    = order_i;
          r_d      = '0;
          idx_d    = off_sh[IDXW-1:0];
          if (32'(order_i) > TOP_ORDER) begin
            status_d = bpa_pkg::ST_BAD_ORDER;
            state_d  = S_DONE;
          end else if (mode_i == bpa_pkg::MODE_FREE) begin
            if (outside) begin
              status_d = bpa_pkg::ST_BAD_ADDR;
              state_d  = S_DONE;
            end else begin
              state_d = S_FREE_RD;
            end
          end else begin
            state_d = S_ALLOC_RD;
          end
        end
      end
      S_FREE_RD: begin
        map_cmd_o.rd = 1'b1;
        state_d      = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        map_cmd_o.wr = 1'b1;
        // merge with a free buddy, else mark this block free
        if (32'(o_q) < TOP_ORDER && map_rdata_i[bcol]) begin
          map_wdata_o = map_rdata_i & ~(W'(1) << bcol);
          idx_d       = idx_q >> 1;
          o_d         = o_q + 1'b1;
          state_d     = S_FREE_RD;
        end else begin
          map_wdata_o = map_rdata_i | (W'(1) << col);
          state_d     = S_DONE;
        end
      end
      S_ALLOC_RD: begin
        map_cmd_o.rd = 1'b1;
        map_addr_o   = order_base(o_q) + RAW'(r_q);
        state_d      = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        map_addr_o = order_base(o_q) + RAW'(r_q);
        if (map_rdata_i != '0) begin
          map_cmd_o.wr = 1'b1;
          map_wdata_o  = map_rdata_i & ~(W'(1) << fcol);
          if (o_q > ord_q) begin
            o_d     = o_q - 1'b1;
            idx_d   = fidx << 1;
            state_d = S_SPLIT_RD;
          end else begin
            idx_d   = fidx;
            state_d = S_ADDR;
          end
        end else if (r_q == last_row) begin
          if (32'(o_q) == TOP_ORDER) begin
            status_d = bpa_pkg::ST_NO_FREE;
            state_d  = S_DONE;
          end else begin
            o_d     = o_q + 1'b1;
            r_d     = '0;
            state_d = S_ALLOC_RD;
          end
        end else begin
          r_d     = r_q + 1'b1;
          state_d = S_ALLOC_RD;
        end
      end
      S_SPLIT_RD: begin
        map_cmd_o.rd = 1'b1;
        state_d      = S_SPLIT_WR;
      end
      S_SPLIT_WR: begin
        // upper half of the split goes free
        map_cmd_o.wr = 1'b1;
        map_wdata_o  = map_rdata_i | (W'(1) << (col | LOG_TP'(1)));
        if (o_q > ord_q) begin
          o_d     = o_q - 1'b1;
          idx_d   = idx_q << 1;
          state_d = S_SPLIT_RD;
        end else begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        shift_d = sh[31:0];
        state_d = S_SUM;
      end
      S_SUM: begin
        blk_d   = region_base_i + shift_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q    <= ord_d;
    o_q      <= o_d;
    idx_q    <= idx_d;
    r_q      <= r_d;
    status_q <= status_d;
    blk_q    <= blk_d;
    shift_q  <= shift_d;
  end

  assign idle_o       = (state_q == S_IDLE);
  assign res_o.valid  = (state_q == S_DONE);
  assign res_o.status = status_q;
  assign res_o.block  = blk_q;

endmodule

@@ rtl/core/buddy_page_allocator.sv @@
// Binary buddy page allocator. The region starts at region_base and holds
// TOP_PAGES blocks of order TOP_ORDER; a block of order o is MIN_PAGE_BYTES << o
// bytes (MIN_PAGE_BYTES, TOP_PAGES powers of two). Each request word carries the
// kind in tuser (0 allocate, 1 free), and returns one result word with a
// status and, for a successful allocate, the block address. Free bitmaps of
// all orders share one RAM with one row per TOP_PAGES blocks; each step of
// the walk is one access of that single port. A free reads the row of its
// block, writes it back and moves up one order per merge with a free buddy.
// An allocate scans rows from the requested order upward until a free block
// is found, splits it down to the requested order, then shifts the index and
// adds region_base to form the address; if it finds nothing it returns a
// no-free status. Bad order or address requests skip the walk. A new request
// is taken while the previous result still waits on the output. The top-order
// last block is reserved after reset; double frees are not detected.
module buddy_page_allocator #(
  parameter int unsigned MIN_PAGE_BYTES = 256,
  parameter int unsigned TOP_ORDER      = 3,
  parameter int unsigned TOP_PAGES      = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: region_base
  input  logic                                cfg_we_i,
  input  logic [bpa_pkg::ADDR_W-1:0]          cfg_wdata_i,
  // Requests
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [bpa_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,  // order[2:0], address[34:3]
  input  logic                                s_axis_tuser_i,  // mode
  // Results
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [bpa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o   // status[1:0], block_address[33:2]
);

  localparam int unsigned LOG_MIN = $clog2(MIN_PAGE_BYTES);
  localparam int unsigned LOG_TP  = $clog2(TOP_PAGES);
  localparam int unsigned ROWS    = (2 ** (TOP_ORDER + 1)) - 1;
  localparam int unsigned RAW     = TOP_ORDER + 1;

  logic [bpa_pkg::ADDR_W-1:0]   region_base_q;
  logic                         idle;
  logic                         start;
  logic                         out_free;
  bpa_pkg::bpa_res_t            res;
  bpa_pkg::map_cmd_t            map_cmd;
  logic [RAW-1:0]               map_addr;
  logic [TOP_PAGES-1:0]         map_wdata;
  logic [TOP_PAGES-1:0]         map_rdata;
  logic                         out_vld_q;
  logic [bpa_pkg::STATUS_W-1:0] out_status_q;
  logic [bpa_pkg::ADDR_W-1:0]   out_block_q;

  // Region base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= '0;
    end else if (cfg_we_i) begin
      region_base_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = idle;
  assign start           = s_axis_tvalid_i & idle;
  assign out_free        = ~out_vld_q | m_axis_tready_i;

  bpa_seq #(
    .LOG_MIN   (LOG_MIN),
    .TOP_ORDER (TOP_ORDER),
    .LOG_TP    (LOG_TP),
    .RAW       (RAW),
    .W         (TOP_PAGES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .mode_i        (s_axis_tuser_i),
    .order_i       (s_axis_tdata_i[2:0]),
    .address_i     (s_axis_tdata_i[34:3]),
    .region_base_i (region_base_q),
    .out_free_i    (out_free),
    .idle_o        (idle),
    .res_o         (res),
    .map_cmd_o     (map_cmd),
    .map_addr_o    (map_addr),
    .map_wdata_o   (map_wdata),
    .map_rdata_i   (map_rdata)
  );

  bpa_map_ram #(
    .ROWS (ROWS),
    .RAW  (RAW),
    .W    (TOP_PAGES)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (map_cmd),
    .addr_i  (map_addr),
    .wdata_i (map_wdata),
    .rdata_o (map_rdata)
  );

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_status_q <= res.status;
      out_block_q  <= res.block;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, out_block_q, out_status_q};

endmodule
